/* hdl/hwr_pkg.sv */
// Shared constants and types for the hue wheel to RGB converter.
`default_nettype none

package hwr_pkg;

    // Port widths
    localparam int HUE_W = 16;
    localparam int SAT_W = 11;
    localparam int BRT_W = 9;
    localparam int CH_W  = 8;

    // Pipeline register stages of the top level
    localparam int STAGES = 7;

    // Fixed point for saturation and brightness
    localparam int FRAC_BITS = 8;
    localparam int ONE       = 1 << FRAC_BITS;

    // Hue geometry, 1/16 degree units
    localparam int FULL_TURN   = 5760;
    localparam int SECTOR_SPAN = 960;
    localparam int SPAN_SHIFT  = 6;              // 960 = 15 << 6
    localparam int HUE_BIAS    = 6 * FULL_TURN;  // lifts any 16-bit hue above zero
    localparam int X_W         = 17;             // biased hue width
    localparam int OFF_W       = 10;             // sector offset, 0..959
    localparam int Q_W         = 7;              // biased hue / 960, 1..70
    localparam int Q6_W        = 4;              // that quotient / 6

    // Reciprocals: y/15 as (y*4370)>>16 for y < 4681, q/6 as (q*43)>>8 for q <= 70
    localparam int RECIP15_W     = 13;
    localparam int RECIP15       = 4370;
    localparam int RECIP15_SHIFT = 16;
    localparam int RECIP6_W      = 6;
    localparam int RECIP6        = 43;
    localparam int RECIP6_SHIFT  = 8;

    // Channel arithmetic: 255*S*I / (960*ONE*ONE) = 17*S*I >> (2*FRAC_BITS + 6)
    localparam int INNER_W   = 18;
    localparam int PROD_W    = INNER_W + BRT_W;
    localparam int SCALED_W  = PROD_W + 5;
    localparam int OUT_SHIFT = 2 * FRAC_BITS + SPAN_SHIFT;
    localparam int CH_MAX    = 255;

    localparam logic [CH_W-1:0] OPAQUE = 8'd255;

    // 60-degree sectors of the hue wheel
    typedef enum logic [2:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5
    } hue_sector_t;

    // Per-stage load enables for the hue front end
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } hue_adv_t;

endpackage

`default_nettype wire

/* hdl/hwr_hue_pipe.sv */
// Hue front end: wraps the hue angle, finds its sector and the ramp weight.
`default_nettype none

module hwr_hue_pipe (
    input  wire logic                            clk,
    input  wire hwr_pkg::hue_adv_t               adv,
    input  wire logic signed [hwr_pkg::HUE_W-1:0] hue_angle,
    output hwr_pkg::hue_sector_t                 sector,
    output logic [hwr_pkg::OFF_W-1:0]            ramp_weight
);

    logic [hwr_pkg::X_W-1:0]  x1_reg;
    logic [hwr_pkg::X_W-1:0]  x2_reg;
    logic [hwr_pkg::Q_W-1:0]  q2_reg;
    logic [hwr_pkg::Q_W-1:0]  q3_reg;
    logic [hwr_pkg::Q6_W-1:0] q6_reg;
    logic [hwr_pkg::OFF_W-1:0] off_reg;
    hwr_pkg::hue_sector_t      sector_reg;
    logic [hwr_pkg::OFF_W-1:0] weight_reg;

    logic [hwr_pkg::X_W-1:0]  x1_next;
    logic [hwr_pkg::X_W+hwr_pkg::RECIP15_W-hwr_pkg::SPAN_SHIFT-1:0] q_prod;
    logic [hwr_pkg::Q_W-1:0]  q2_next;
    logic [hwr_pkg::X_W-1:0]  q_span;
    logic [hwr_pkg::X_W-1:0]  off_full;
    logic [hwr_pkg::Q_W+hwr_pkg::RECIP6_W-1:0] q6_prod;
    logic [hwr_pkg::Q6_W-1:0] q6_next;
    logic [hwr_pkg::Q_W-1:0]  sect_full;
    logic [2:0]               sector_next;
    logic [hwr_pkg::OFF_W-1:0] weight_next;

    // Stage 1: bias the signed hue into a positive 17-bit value (modulo 2^17)
    assign x1_next = {hue_angle[hwr_pkg::HUE_W-1], hue_angle}
                   + hwr_pkg::X_W'(hwr_pkg::HUE_BIAS);

    // Stage 2: quotient by the sector span, (x >> 6) / 15 by reciprocal
    assign q_prod  = (hwr_pkg::X_W+hwr_pkg::RECIP15_W-hwr_pkg::SPAN_SHIFT)'(
                         x1_reg[hwr_pkg::X_W-1:hwr_pkg::SPAN_SHIFT])
                   * (hwr_pkg::X_W+hwr_pkg::RECIP15_W-hwr_pkg::SPAN_SHIFT)'(hwr_pkg::RECIP15);
    assign q2_next = q_prod[hwr_pkg::RECIP15_SHIFT +: hwr_pkg::Q_W];

    // Stage 3: offset inside the sector, and quotient by six turns
    assign q_span   = (hwr_pkg::X_W)'(q2_reg) * (hwr_pkg::X_W)'(hwr_pkg::SECTOR_SPAN);
    assign off_full = x2_reg - q_span;
    assign q6_prod  = (hwr_pkg::Q_W+hwr_pkg::RECIP6_W)'(q2_reg)
                    * (hwr_pkg::Q_W+hwr_pkg::RECIP6_W)'(hwr_pkg::RECIP6);
    assign q6_next  = q6_prod[hwr_pkg::RECIP6_SHIFT +: hwr_pkg::Q6_W];

    // Stage 4: sector number, ramp weight falls across odd sectors
    assign sect_full   = q3_reg - hwr_pkg::Q_W'(q6_reg) * hwr_pkg::Q_W'(3'd6);
    assign sector_next = sect_full[2:0];
    assign weight_next = sector_next[0]
                       ? hwr_pkg::OFF_W'(hwr_pkg::SECTOR_SPAN) - off_reg
                       : off_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            x1_reg <= x1_next;
        end
        if (adv.s2)
        begin
            x2_reg <= x1_reg;
            q2_reg <= q2_next;
        end
        if (adv.s3)
        begin
            off_reg <= off_full[hwr_pkg::OFF_W-1:0];
            q3_reg  <= q2_reg;
            q6_reg  <= q6_next;
        end
        if (adv.s4)
        begin
            sector_reg <= hwr_pkg::hue_sector_t'(sector_next);
            weight_reg <= weight_next;
        end
    end

    assign sector      = sector_reg;
    assign ramp_weight = weight_reg;

endmodule

`default_nettype wire

/* hdl/hue_wheel_to_rgb.sv */
// Top level: pipelined hue / saturation / brightness to 8-bit RGBA converter.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   hsv     | hsv_valid, hsv_stall | hue_angle[15:0] s, saturation[10:0] s,
//           |                      | brightness[8:0]
//   rgb     | rgb_valid, rgb_stall | red, green, blue, alpha (8 bits each)
//
// Seven register stages; one transfer per clock on each side when nothing stalls.
// A result moves from stage to stage as each advances and leaves from stage 7,
// whose valid bit drives rgb_valid.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and a stalled result holds while earlier stages keep filling.
// Reset clears only the stage valid bits.
`default_nettype none

module hue_wheel_to_rgb (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             hsv_valid,
    output logic                                  hsv_stall,
    input  wire logic signed [hwr_pkg::HUE_W-1:0] hue_angle,
    input  wire logic signed [hwr_pkg::SAT_W-1:0] saturation,
    input  wire logic [hwr_pkg::BRT_W-1:0]        brightness,
    output logic                                  rgb_valid,
    input  wire logic                             rgb_stall,
    output logic [hwr_pkg::CH_W-1:0]              red,
    output logic [hwr_pkg::CH_W-1:0]              green,
    output logic [hwr_pkg::CH_W-1:0]              blue,
    output logic [hwr_pkg::CH_W-1:0]              alpha
);

    logic [hwr_pkg::STAGES:1] vld_reg;
    logic [hwr_pkg::STAGES:1] adv;
    hwr_pkg::hue_adv_t hue_adv;

    // saturation and brightness travel alongside the hue front end
    logic [hwr_pkg::BRT_W-1:0] r_reg  [1:4];
    logic [hwr_pkg::BRT_W-1:0] s_reg  [1:5];
    logic [hwr_pkg::BRT_W-1:0] r_next;
    logic [hwr_pkg::BRT_W-1:0] s_next;

    hwr_pkg::hue_sector_t      sector4;
    logic [hwr_pkg::OFF_W-1:0] weight4;
    hwr_pkg::hue_sector_t      sector_reg [5:6];

    logic [hwr_pkg::INNER_W-1:0] ramp_in_reg;
    logic [hwr_pkg::INNER_W-1:0] min_in_reg;
    logic [hwr_pkg::BRT_W-1:0]   m_dif;
    logic [hwr_pkg::INNER_W-1:0] min_in_next;
    logic [hwr_pkg::INNER_W-1:0] ramp_in_next;

    logic [hwr_pkg::PROD_W-1:0]  ramp_prod_reg;
    logic [hwr_pkg::PROD_W-1:0]  min_prod_reg;
    logic [hwr_pkg::CH_W-1:0]    dom_reg;
    logic [hwr_pkg::BRT_W+hwr_pkg::CH_W-1:0] dom_full;

    logic [hwr_pkg::SCALED_W-1:0] ramp_scaled;
    logic [hwr_pkg::SCALED_W-1:0] min_scaled;
    logic [hwr_pkg::CH_W-1:0]     ramp_ch;
    logic [hwr_pkg::CH_W-1:0]     min_ch;
    logic [hwr_pkg::CH_W-1:0]     red_next;
    logic [hwr_pkg::CH_W-1:0]     green_next;
    logic [hwr_pkg::CH_W-1:0]     blue_next;
    logic [hwr_pkg::CH_W-1:0]     red_reg;
    logic [hwr_pkg::CH_W-1:0]     green_reg;
    logic [hwr_pkg::CH_W-1:0]     blue_reg;

    // Stage advance: load when empty or when the next stage moves
    always_comb
    begin
        adv[hwr_pkg::STAGES] = !vld_reg[hwr_pkg::STAGES] || !rgb_stall;
        for (int k = hwr_pkg::STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign hsv_stall = !adv[1];
    assign hue_adv   = '{s1: adv[1], s2: adv[2], s3: adv[3], s4: adv[4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                vld_reg[1] <= hsv_valid;
            end
            for (int k = 2; k <= hwr_pkg::STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Hue wrap, sector and ramp weight (stages 1 to 4)
    hwr_hue_pipe u_hue (
        .clk         (clk),
        .adv         (hue_adv),
        .hue_angle   (hue_angle),
        .sector      (sector4),
        .ramp_weight (weight4)
    );

    // Stage 1: clamp saturation to 0..ONE and brightness to at most ONE
    always_comb
    begin
        if (saturation[hwr_pkg::SAT_W-1])
        begin
            r_next = '0;
        end
        else if (saturation[hwr_pkg::SAT_W-2:0] > (hwr_pkg::SAT_W-1)'(hwr_pkg::ONE))
        begin
            r_next = hwr_pkg::BRT_W'(hwr_pkg::ONE);
        end
        else
        begin
            r_next = saturation[hwr_pkg::BRT_W-1:0];
        end
        s_next = (brightness > hwr_pkg::BRT_W'(hwr_pkg::ONE))
               ? hwr_pkg::BRT_W'(hwr_pkg::ONE) : brightness;
    end

    // Stage 5: inner sums, 960*(ONE-R) + D*R and 960*(ONE-R)
    assign m_dif        = hwr_pkg::BRT_W'(hwr_pkg::ONE) - r_reg[4];
    assign min_in_next  = hwr_pkg::INNER_W'(m_dif) * hwr_pkg::INNER_W'(hwr_pkg::SECTOR_SPAN);
    assign ramp_in_next = min_in_next
                        + hwr_pkg::INNER_W'(weight4) * hwr_pkg::INNER_W'(r_reg[4]);

    // Stage 6 dominant channel: 255*S >> FRAC_BITS
    assign dom_full = (hwr_pkg::BRT_W+hwr_pkg::CH_W)'(s_reg[5])
                    * (hwr_pkg::BRT_W+hwr_pkg::CH_W)'(hwr_pkg::CH_MAX);

    // Stage 7: scale by 17 and drop the fraction, then route by sector
    assign ramp_scaled = (hwr_pkg::SCALED_W'(ramp_prod_reg) << 4)
                       + hwr_pkg::SCALED_W'(ramp_prod_reg);
    assign min_scaled  = (hwr_pkg::SCALED_W'(min_prod_reg) << 4)
                       + hwr_pkg::SCALED_W'(min_prod_reg);
    assign ramp_ch     = ramp_scaled[hwr_pkg::OUT_SHIFT +: hwr_pkg::CH_W];
    assign min_ch      = min_scaled[hwr_pkg::OUT_SHIFT +: hwr_pkg::CH_W];

    always_comb
    begin
        case (sector_reg[6])
            hwr_pkg::SECT_RED_YELLOW:
            begin
                red_next = dom_reg;  green_next = ramp_ch; blue_next = min_ch;
            end
            hwr_pkg::SECT_YELLOW_GREEN:
            begin
                red_next = ramp_ch;  green_next = dom_reg; blue_next = min_ch;
            end
            hwr_pkg::SECT_GREEN_CYAN:
            begin
                red_next = min_ch;   green_next = dom_reg; blue_next = ramp_ch;
            end
            hwr_pkg::SECT_CYAN_BLUE:
            begin
                red_next = min_ch;   green_next = ramp_ch; blue_next = dom_reg;
            end
            hwr_pkg::SECT_BLUE_MAGENTA:
            begin
                red_next = ramp_ch;  green_next = min_ch;  blue_next = dom_reg;
            end
            default:
            begin
                red_next = dom_reg;  green_next = min_ch;  blue_next = ramp_ch;
            end
        endcase
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            r_reg[1] <= r_next;
            s_reg[1] <= s_next;
        end
        for (int k = 2; k <= 4; k++)
        begin
            if (adv[k])
            begin
                r_reg[k] <= r_reg[k-1];
            end
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (adv[k])
            begin
                s_reg[k] <= s_reg[k-1];
            end
        end
        if (adv[5])
        begin
            sector_reg[5] <= sector4;
            ramp_in_reg   <= ramp_in_next;
            min_in_reg    <= min_in_next;
        end
        if (adv[6])
        begin
            sector_reg[6] <= sector_reg[5];
            ramp_prod_reg <= hwr_pkg::PROD_W'(s_reg[5]) * hwr_pkg::PROD_W'(ramp_in_reg);
            min_prod_reg  <= hwr_pkg::PROD_W'(s_reg[5]) * hwr_pkg::PROD_W'(min_in_reg);
            dom_reg       <= dom_full[hwr_pkg::FRAC_BITS +: hwr_pkg::CH_W];
        end
        if (adv[7])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb_valid = vld_reg[hwr_pkg::STAGES];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha     = hwr_pkg::OPAQUE;

endmodule

`default_nettype wire
